>>> rtl/float_literal_recognizer_top_assert.svh
// Assertion macros for the float literal recognizer.
// Uses the clk and rst_n signals of the module that includes this file.
`ifndef FLOAT_LITERAL_RECOGNIZER_TOP_ASSERT_SVH
`define FLOAT_LITERAL_RECOGNIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define FLR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flr assertion failed");

// Next-cycle implication, disabled in reset
`define FLR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flr assertion failed");

`endif

>>> rtl/flr_pkg.sv
// Shared types, codes and character helpers of the float literal recognizer.
// No dependencies.
package flr_pkg;

    localparam logic [7:0] DECIMAL_POINT_RESET = 8'd46;
    localparam logic       REG_DECIMAL_POINT   = 1'b0;

    typedef enum logic [3:0] {
        PS_SIGNED    = 4'd0,
        PS_MANT      = 4'd1,
        PS_MANT_END  = 4'd2,
        PS_FRAC      = 4'd3,
        PS_EXP_MARK  = 4'd4,
        PS_EXP_SIGN  = 4'd5,
        PS_EXP_DIGIT = 4'd6,
        PS_EXP_MORE  = 4'd7,
        PS_TRAIL     = 4'd8,
        PS_ZERO      = 4'd9,
        PS_START     = 4'd10,
        PS_WORD      = 4'd11,
        PS_VALID     = 4'd12,
        PS_FAILED    = 4'd13
    } parse_state_t;

    typedef enum logic [1:0] {
        ACT_STORE = 2'd0,
        ACT_DONE  = 2'd1,
        ACT_ERROR = 2'd2
    } act_t;

    typedef enum logic [1:0] {
        OUT_STORED = 2'd0,
        OUT_VALID  = 2'd1,
        OUT_FAILED = 2'd2
    } outcome_t;

    typedef struct packed {
        parse_state_t st;
        logic         hex_mode;
        logic         seen_hex_prefix;
        logic         saw_digits;
        logic         word_is_infinity;
        logic [2:0]   match_pos;
        logic [15:0]  width_left;
    } flr_ctx_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= "A") && (c <= "Z");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return is_upper(c) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return is_upper(c) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_xdigit(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        return is_digit(c) || ((l >= "a") && (l <= "f"));
    endfunction

    function automatic logic [7:0] nan_char(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = "a";
            3'd1:    r = "n";
            3'd2:    r = "s";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] inf_char(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = "n";
            3'd1:    r = "f";
            3'd2:    r = "i";
            3'd3:    r = "n";
            3'd4:    r = "i";
            3'd5:    r = "t";
            3'd6:    r = "y";
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/flr_core.sv
// Per-character next-state and outcome logic of the float literal recognizer.
// Depends on flr_pkg.
module flr_core (
    input  flr_pkg::flr_ctx_t cur,
    input  logic [7:0]        ch,
    input  logic              end_of_input,
    input  logic              first,
    input  logic [15:0]       field_width,
    input  logic [7:0]        decimal_point,
    output flr_pkg::flr_ctx_t nxt,
    output flr_pkg::outcome_t outcome,
    output logic              hex_literal
);

    flr_pkg::flr_ctx_t     eff;
    flr_pkg::act_t         act;
    flr_pkg::parse_state_t s;
    logic                  res;
    logic                  term;

    logic       c_ok;
    logic       is_dig;
    logic       is_xd;
    logic       is_sg;
    logic       is_zero;
    logic       is_x;
    logic       is_n;
    logic       is_i;
    logic       is_dp;
    logic       is_ex;
    logic [2:0] wlen;
    logic [7:0] wc;
    logic       wmatch;

    always_comb
    begin
        eff = cur;
        if (first)
        begin
            eff.st               = flr_pkg::PS_START;
            eff.hex_mode         = 1'b0;
            eff.seen_hex_prefix  = 1'b0;
            eff.saw_digits       = 1'b0;
            eff.word_is_infinity = 1'b0;
            eff.match_pos        = 3'd0;
            eff.width_left       = field_width;
        end
    end

    assign c_ok    = !end_of_input;
    assign is_dig  = c_ok && flr_pkg::is_digit(ch);
    assign is_xd   = c_ok && eff.hex_mode && flr_pkg::is_xdigit(ch);
    assign is_sg   = c_ok && ((ch == "+") || (ch == "-"));
    assign is_zero = c_ok && (ch == "0");
    assign is_x    = c_ok && ((ch == "x") || (ch == "X"));
    assign is_n    = c_ok && ((ch == "n") || (ch == "N"));
    assign is_i    = c_ok && ((ch == "i") || (ch == "I"));
    assign is_dp   = c_ok && (ch == decimal_point);
    assign is_ex   = c_ok && ((ch == "e") || (ch == "E")
                     || (eff.hex_mode && ((ch == "p") || (ch == "P"))));

    assign wlen   = eff.word_is_infinity ? 3'd7 : 3'd3;
    assign wc     = (eff.match_pos < wlen)
                    ? (eff.word_is_infinity ? flr_pkg::inf_char(eff.match_pos)
                                            : flr_pkg::nan_char(eff.match_pos))
                    : 8'd0;
    assign wmatch = c_ok && (wc != 8'd0) && flr_pkg::is_alpha(ch)
                    && (flr_pkg::to_lower(ch) == wc);

    // Next state: walk the fall-through chain once, resolving at the first match
    always_comb
    begin
        nxt  = eff;
        act  = flr_pkg::ACT_ERROR;
        s    = eff.st;
        res  = 1'b0;
        term = (eff.st == flr_pkg::PS_VALID) || (eff.st == flr_pkg::PS_FAILED);
        if (term)
        begin
            nxt = eff;
        end
        else if (eff.width_left == 16'd0)
        begin
            act = flr_pkg::ACT_DONE;
        end
        else
        begin
            nxt.width_left = eff.width_left - 16'd1;
            if (!res && (s == flr_pkg::PS_START))
            begin
                if (is_sg)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_SIGNED; res = 1'b1;
                end
                else
                begin
                    s = flr_pkg::PS_SIGNED;
                end
            end
            if (!res && (s == flr_pkg::PS_SIGNED))
            begin
                if (is_zero)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_ZERO;
                    nxt.saw_digits = 1'b1; res = 1'b1;
                end
                else if (is_n || is_i)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_WORD;
                    nxt.word_is_infinity = is_i; nxt.match_pos = 3'd0; res = 1'b1;
                end
                else
                begin
                    s = flr_pkg::PS_MANT;
                end
            end
            if (!res && (s == flr_pkg::PS_ZERO))
            begin
                if (is_x)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_MANT;
                    nxt.hex_mode = 1'b1; nxt.seen_hex_prefix = 1'b1;
                    nxt.saw_digits = 1'b0; res = 1'b1;
                end
                else
                begin
                    s = flr_pkg::PS_MANT;
                end
            end
            if (!res && ((s == flr_pkg::PS_MANT) || (s == flr_pkg::PS_FRAC)
                         || (s == flr_pkg::PS_EXP_MORE)))
            begin
                if (is_dig || is_xd)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = s;
                    nxt.saw_digits = 1'b1; res = 1'b1;
                end
                else
                begin
                    unique case (s)
                        flr_pkg::PS_MANT: s = flr_pkg::PS_MANT_END;
                        flr_pkg::PS_FRAC: s = flr_pkg::PS_EXP_MARK;
                        default:          s = flr_pkg::PS_TRAIL;
                    endcase
                end
            end
            if (!res && (s == flr_pkg::PS_MANT_END))
            begin
                if (is_dp)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_FRAC; res = 1'b1;
                end
                else
                begin
                    s = flr_pkg::PS_EXP_MARK;
                end
            end
            if (!res && (s == flr_pkg::PS_EXP_MARK))
            begin
                if (is_ex)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_EXP_SIGN;
                    nxt.hex_mode = 1'b0;
                end
                else
                begin
                    act = eff.hex_mode ? flr_pkg::ACT_ERROR : flr_pkg::ACT_DONE;
                end
                res = 1'b1;
            end
            if (!res && (s == flr_pkg::PS_EXP_SIGN))
            begin
                if (is_sg)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_EXP_DIGIT; res = 1'b1;
                end
                else
                begin
                    s = flr_pkg::PS_EXP_DIGIT;
                end
            end
            if (!res && (s == flr_pkg::PS_EXP_DIGIT))
            begin
                if (is_dig)
                begin
                    act = flr_pkg::ACT_STORE; nxt.st = flr_pkg::PS_EXP_MORE;
                end
                else
                begin
                    act = flr_pkg::ACT_ERROR;
                end
                res = 1'b1;
            end
            if (!res && (s == flr_pkg::PS_TRAIL))
            begin
                act = flr_pkg::ACT_DONE; res = 1'b1;
            end
            if (!res && (s == flr_pkg::PS_WORD))
            begin
                if (wmatch)
                begin
                    act = flr_pkg::ACT_STORE; nxt.match_pos = eff.match_pos + 3'd1;
                end
                else
                begin
                    act = flr_pkg::ACT_DONE;
                    if ((eff.match_pos == wlen) || (eff.match_pos == 3'd2))
                    begin
                        nxt.saw_digits = 1'b1;
                    end
                end
                res = 1'b1;
            end
        end
        if (!term && (act != flr_pkg::ACT_STORE))
        begin
            nxt.st = ((act == flr_pkg::ACT_DONE) && nxt.saw_digits)
                     ? flr_pkg::PS_VALID : flr_pkg::PS_FAILED;
        end
    end

    always_comb
    begin
        priority if (term)
        begin
            outcome = (eff.st == flr_pkg::PS_VALID) ? flr_pkg::OUT_VALID
                                                    : flr_pkg::OUT_FAILED;
        end
        else if (act == flr_pkg::ACT_STORE)
        begin
            outcome = flr_pkg::OUT_STORED;
        end
        else if (nxt.st == flr_pkg::PS_VALID)
        begin
            outcome = flr_pkg::OUT_VALID;
        end
        else
        begin
            outcome = flr_pkg::OUT_FAILED;
        end
        hex_literal = nxt.seen_hex_prefix;
    end

endmodule

>>> rtl/float_literal_recognizer_top.sv
// Float literal recognizer top: one character per word, one outcome word out,
// takes one word every cycle while the output is not stalled; the outcome is
// registered from the combinational parse step in flr_core. The decimal point
// character sits in the register at byte address 0 (reset '.'). Depends on flr_pkg,
// flr_core and float_literal_recognizer_top_assert.svh.
`include "float_literal_recognizer_top_assert.svh"

module float_literal_recognizer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // ch[7:0], field_width[23:8]
    input  logic [1:0]  s_tuser,   // end_of_input[0], first[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // outcome[1:0], zero[7:2]
    output logic [0:0]  m_tuser,   // hex_literal[0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    flr_pkg::flr_ctx_t ctx_reg;
    flr_pkg::flr_ctx_t ctx_next;
    flr_pkg::outcome_t outcome_next;
    flr_pkg::outcome_t outcome_reg;
    logic              hex_next;
    logic              hex_reg;
    logic              valid_reg;
    logic [7:0]        dp_reg;
    logic              s_accept;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == flr_pkg::REG_DECIMAL_POINT);
    assign prdata    = (paddr[2] == flr_pkg::REG_DECIMAL_POINT) ? {24'd0, dp_reg} : 32'd0;

    assign s_tready = !valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, outcome_reg};
    assign m_tuser  = hex_reg;

    flr_core u_core (
        .cur           (ctx_reg),
        .ch            (s_tdata[7:0]),
        .end_of_input  (s_tuser[0]),
        .first         (s_tuser[1]),
        .field_width   (s_tdata[23:8]),
        .decimal_point (dp_reg),
        .nxt           (ctx_next),
        .outcome       (outcome_next),
        .hex_literal   (hex_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_reg <= flr_pkg::DECIMAL_POINT_RESET;
        end
        else if (cfg_write)
        begin
            dp_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg.st               <= flr_pkg::PS_START;
            ctx_reg.hex_mode         <= 1'b0;
            ctx_reg.seen_hex_prefix  <= 1'b0;
            ctx_reg.saw_digits       <= 1'b0;
            ctx_reg.word_is_infinity <= 1'b0;
            ctx_reg.match_pos        <= 3'd0;
            ctx_reg.width_left       <= 16'd0;
            valid_reg                <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                ctx_reg <= ctx_next;
            end
            if (s_accept)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the result word on accept
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            outcome_reg <= outcome_next;
            hex_reg     <= hex_next;
        end
    end

    `FLR_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)
    `FLR_ASSERT_NXT(a_valid_sticks,
        s_accept && !s_tuser[1] && (ctx_reg.st == flr_pkg::PS_VALID),
        ctx_reg.st == flr_pkg::PS_VALID)
    `FLR_ASSERT_NXT(a_width_counts_down,
        s_accept && !s_tuser[1] && (ctx_reg.width_left != 16'd0)
        && (ctx_reg.st != flr_pkg::PS_VALID) && (ctx_reg.st != flr_pkg::PS_FAILED),
        ctx_reg.width_left == $past(ctx_reg.width_left) - 16'd1)
    `FLR_ASSERT_NXT(a_start_on_empty_fails,
        s_accept && s_tuser[1] && s_tuser[0],
        outcome_reg == flr_pkg::OUT_FAILED)

endmodule

>>> sim/float_literal_recognizer_top_test.sv
// Self-checking bench for float_literal_recognizer_top: character words in, outcome words out.
// Expected outcomes come from a local copy of the literal parser, checked in order.
// Depends on flr_pkg and the float_literal_recognizer_top RTL.
module float_literal_recognizer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]   DP_ADDR     = 3'd0;
    localparam int           QUIET_LIMIT = 2000;
    localparam logic [8:0]   NO_CHAR     = 9'h100;
    localparam logic [55:0]  INF_TAIL    = "nfinity";
    localparam logic [23:0]  NAN_TAIL    = "ans";
    localparam logic [175:0] HEX_DIGITS  = "0123456789abcdefABCDEF";

    typedef struct packed {
        flr_pkg::outcome_t outcome;
        logic              hex;
    } verdict_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // ch[7:0], field_width[23:8]
    logic [1:0]  s_tuser  = '0;   // end_of_input[0], first[1]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // outcome[1:0], zero[7:2]
    logic [0:0]  m_tuser;         // hex_literal[0]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int idle_pct   = 0;
    int stall_pct  = 0;
    int mismatches = 0;

    verdict_t   verdict_q[$];
    logic [8:0] text_q[$];

    logic [7:0]  dp_char;
    logic [3:0]  lit_state;
    logic        lit_hex_mode;
    logic        lit_hex_prefix;
    logic        lit_digits;
    logic        lit_inf_word;
    logic [2:0]  lit_pos;
    logic [15:0] lit_budget;

    float_literal_recognizer_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [8:0] chr(input logic [7:0] c);
        return {1'b0, c};
    endfunction

    function automatic logic chr_digit(input logic [8:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [8:0] chr_lower(input logic [8:0] c);
        return ((c >= "A") && (c <= "Z")) ? c + 9'd32 : c;
    endfunction

    function automatic logic chr_alpha(input logic [8:0] c);
        logic [8:0] l;
        l = chr_lower(c);
        return (l >= "a") && (l <= "z");
    endfunction

    function automatic logic chr_xdigit(input logic [8:0] c);
        logic [8:0] l;
        l = chr_lower(c);
        return chr_digit(c) || ((l >= "a") && (l <= "f"));
    endfunction

    function automatic logic [8:0] word_letter(input logic inf, input logic [2:0] pos);
        if (inf)
            return (pos < 3'd7) ? chr(INF_TAIL[8*(6-int'(pos)) +: 8]) : 9'd0;
        return (pos < 3'd3) ? chr(NAN_TAIL[8*(2-int'(pos)) +: 8]) : 9'd0;
    endfunction

    function automatic void clear_literal();
        lit_state      = flr_pkg::PS_START;
        lit_hex_mode   = 1'b0;
        lit_hex_prefix = 1'b0;
        lit_digits     = 1'b0;
        lit_inf_word   = 1'b0;
        lit_pos        = 3'd0;
    endfunction

    function automatic flr_pkg::act_t advance_literal(input logic [8:0] c);
        logic [3:0]     s;
        flr_pkg::act_t  act;
        logic           again;
        logic [2:0]     len;
        logic [8:0]     wc;
        s     = lit_state;
        act   = flr_pkg::ACT_ERROR;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (s)
                flr_pkg::PS_START:
                begin
                    s = flr_pkg::PS_SIGNED;
                    if (c == "+" || c == "-")
                        act = flr_pkg::ACT_STORE;
                    else
                        again = 1'b1;
                end
                flr_pkg::PS_SIGNED:
                begin
                    if (c == "0")
                    begin
                        s          = flr_pkg::PS_ZERO;
                        lit_digits = 1'b1;
                        act        = flr_pkg::ACT_STORE;
                    end
                    else if (c == "n" || c == "N" || c == "i" || c == "I")
                    begin
                        lit_inf_word = (c == "i" || c == "I");
                        lit_pos      = 3'd0;
                        s            = flr_pkg::PS_WORD;
                        act          = flr_pkg::ACT_STORE;
                    end
                    else
                    begin
                        s     = flr_pkg::PS_MANT;
                        again = 1'b1;
                    end
                end
                flr_pkg::PS_WORD:
                begin
                    len = lit_inf_word ? 3'd7 : 3'd3;
                    wc  = word_letter(lit_inf_word, lit_pos);
                    if (wc != 9'd0 && chr_alpha(c) && chr_lower(c) == wc)
                    begin
                        lit_pos = lit_pos + 3'd1;
                        act     = flr_pkg::ACT_STORE;
                    end
                    else
                    begin
                        if (lit_pos == len || lit_pos == 3'd2)
                            lit_digits = 1'b1;
                        act = flr_pkg::ACT_DONE;
                    end
                end
                flr_pkg::PS_ZERO:
                begin
                    s = flr_pkg::PS_MANT;
                    if (c == "x" || c == "X")
                    begin
                        lit_hex_mode   = 1'b1;
                        lit_hex_prefix = 1'b1;
                        lit_digits     = 1'b0;
                        act            = flr_pkg::ACT_STORE;
                    end
                    else
                        again = 1'b1;
                end
                flr_pkg::PS_MANT, flr_pkg::PS_FRAC, flr_pkg::PS_EXP_MORE:
                begin
                    if (!chr_digit(c) && !(lit_hex_mode && chr_xdigit(c)))
                    begin
                        s     = s + 4'd1;
                        again = 1'b1;
                    end
                    else
                    begin
                        lit_digits = 1'b1;
                        act        = flr_pkg::ACT_STORE;
                    end
                end
                flr_pkg::PS_MANT_END:
                begin
                    if (c == chr(dp_char))
                    begin
                        s   = flr_pkg::PS_FRAC;
                        act = flr_pkg::ACT_STORE;
                    end
                    else
                    begin
                        s     = flr_pkg::PS_EXP_MARK;
                        again = 1'b1;
                    end
                end
                flr_pkg::PS_EXP_MARK:
                begin
                    if (c == "E" || c == "e" || (lit_hex_mode && (c == "P" || c == "p")))
                    begin
                        s            = flr_pkg::PS_EXP_SIGN;
                        lit_hex_mode = 1'b0;
                        act          = flr_pkg::ACT_STORE;
                    end
                    else
                        act = lit_hex_mode ? flr_pkg::ACT_ERROR : flr_pkg::ACT_DONE;
                end
                flr_pkg::PS_EXP_SIGN:
                begin
                    s = flr_pkg::PS_EXP_DIGIT;
                    if (c == "+" || c == "-")
                        act = flr_pkg::ACT_STORE;
                    else
                        again = 1'b1;
                end
                flr_pkg::PS_EXP_DIGIT:
                begin
                    if (chr_digit(c))
                    begin
                        s   = flr_pkg::PS_EXP_MORE;
                        act = flr_pkg::ACT_STORE;
                    end
                    else
                        act = flr_pkg::ACT_ERROR;
                end
                flr_pkg::PS_TRAIL:
                    act = flr_pkg::ACT_DONE;
                default:
                    act = flr_pkg::ACT_ERROR;
            endcase
        end
        lit_state = s;
        return act;
    endfunction

    function automatic verdict_t predict_outcome(input logic [7:0] ch, input logic eoi,
                                                 input logic first, input logic [15:0] fw);
        logic [8:0]    c;
        flr_pkg::act_t act;
        verdict_t      v;
        c = eoi ? NO_CHAR : chr(ch);
        if (first)
        begin
            clear_literal();
            lit_budget = fw;
        end
        if (lit_state >= flr_pkg::PS_VALID)
            v.outcome = (lit_state == flr_pkg::PS_VALID) ? flr_pkg::OUT_VALID
                                                         : flr_pkg::OUT_FAILED;
        else
        begin
            if (lit_budget == 16'd0)
                act = flr_pkg::ACT_DONE;
            else
            begin
                lit_budget = lit_budget - 16'd1;
                act = advance_literal(c);
            end
            if (act == flr_pkg::ACT_STORE)
                v.outcome = flr_pkg::OUT_STORED;
            else if (act == flr_pkg::ACT_DONE && lit_digits)
            begin
                lit_state = flr_pkg::PS_VALID;
                v.outcome = flr_pkg::OUT_VALID;
            end
            else
            begin
                lit_state = flr_pkg::PS_FAILED;
                v.outcome = flr_pkg::OUT_FAILED;
            end
        end
        v.hex = lit_hex_prefix;
        return v;
    endfunction

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected outcome word: expected none, got tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (m_tdata !== {6'd0, want.outcome})
                begin
                    $display("%0t: outcome mismatch: expected %h, got %h",
                             $time, {6'd0, want.outcome}, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.hex)
                begin
                    $display("%0t: hex_literal mismatch: expected %b, got %b",
                             $time, want.hex, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_char(input logic [7:0] ch, input logic eoi, input logic first,
                             input logic [15:0] fw);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {fw, ch};
        s_tuser  <= {first, eoi};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        verdict_q.push_back(predict_outcome(ch, eoi, first, fw));
    endtask

    task automatic send_text(input logic [15:0] fw);
        int i;
        for (i = 0; i < text_q.size(); i++)
            send_char(text_q[i][7:0], text_q[i][8], i == 0, (i == 0) ? fw : 16'($urandom));
    endtask

    task automatic load_text(input string s);
        int i;
        text_q.delete();
        for (i = 0; i < s.len(); i++)
            text_q.push_back(chr(8'(s[i])));
    endtask

    // drop valid and drain before touching the register
    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DP_ADDR)
            dp_char = data[7:0];
    endtask

    task automatic set_decimal_point(input logic [7:0] c);
        settle();
        write_reg(DP_ADDR, {24'($urandom), c});
    endtask

    task automatic test_start_and_width();
        send_char("1", 1'b0, 1'b0, 16'hFFFF);
        send_char("7", 1'b0, 1'b1, 16'd0);
        load_text("inf");
        send_text(16'd2);
        send_char("f", 1'b0, 1'b0, 16'h0000);
        load_text("1ex");
        send_text(16'd2);
    endtask

    task automatic test_literals();
        load_text("-1e+");
        text_q.push_back(NO_CHAR);
        send_text(16'hFFFF);
        load_text("nans");
        text_q.push_back(chr(8'hFF));
        send_text(16'hFFFF);
        load_text("0Xfp1");
        text_q.push_back(NO_CHAR | 9'h0FF);
        send_text(16'hFFFF);
        load_text("0x1");
        text_q.push_back(chr(8'h00));
        send_text(16'h8000);
    endtask

    task automatic test_decimal_point();
        set_decimal_point(",");
        load_text("3,25");
        text_q.push_back(NO_CHAR);
        send_text(16'hFFFF);
        load_text("3.");
        send_text(16'hFFFF);
        set_decimal_point("e");
        load_text("1e5");
        text_q.push_back(NO_CHAR);
        send_text(16'hFFFF);
        set_decimal_point("5");
        load_text("15");
        text_q.push_back(NO_CHAR);
        send_text(16'hFFFF);
        set_decimal_point(8'h00);
        load_text("7");
        text_q.push_back(chr(8'h00));
        text_q.push_back(chr("1"));
        text_q.push_back(NO_CHAR);
        send_text(16'hFFFF);
        set_decimal_point(8'hFF);
        load_text("8");
        text_q.push_back(chr(8'hFF));
        text_q.push_back(NO_CHAR);
        send_text(16'hFFFF);
        set_decimal_point(".");
    endtask

    function automatic logic [8:0] pick_digit(input logic hex);
        if (hex)
            return chr(HEX_DIGITS[8*(21-int'($urandom_range(0, 21))) +: 8]);
        return chr(8'("0") + 8'($urandom_range(0, 9)));
    endfunction

    task automatic push_digits(input int n, input logic hex);
        int i;
        for (i = 0; i < n; i++)
            text_q.push_back(pick_digit(hex));
    endtask

    task automatic push_sign();
        text_q.push_back(chr($urandom_range(0, 1) ? "+" : "-"));
    endtask

    // mostly well-formed literals with random content, some noise and corruption
    task automatic build_literal();
        int         pick;
        int         n;
        int         i;
        logic       hex;
        logic [7:0] b;
        string      word;
        text_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                text_q.push_back(chr(8'($urandom)));
        end
        else
        begin
            if ($urandom_range(0, 2) == 0)
                push_sign();
            if (pick < 32)
            begin
                case ($urandom_range(0, 3))
                    0:       word = "nan";
                    1:       word = "nans";
                    2:       word = "inf";
                    default: word = "infinity";
                endcase
                n = word.len();
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, n);
                for (i = 0; i < n; i++)
                begin
                    b = 8'(word[i]);
                    if ($urandom_range(0, 1))
                        b = b - 8'd32;
                    text_q.push_back(chr(b));
                end
            end
            else
            begin
                hex = ($urandom_range(0, 2) == 0);
                if (hex)
                begin
                    text_q.push_back(chr("0"));
                    text_q.push_back(chr($urandom_range(0, 1) ? "x" : "X"));
                end
                else if ($urandom_range(0, 3) == 0)
                    text_q.push_back(chr("0"));
                push_digits($urandom_range(0, 4), hex);
                if ($urandom_range(0, 1))
                begin
                    text_q.push_back(chr(($urandom_range(0, 3) == 0) ? 8'("." ) : dp_char));
                    push_digits($urandom_range(0, 3), hex);
                end
                if ((hex && $urandom_range(0, 7) != 0) || (!hex && $urandom_range(0, 1)))
                begin
                    if (hex ^ ($urandom_range(0, 9) == 0))
                        text_q.push_back(chr($urandom_range(0, 1) ? "p" : "P"));
                    else
                        text_q.push_back(chr($urandom_range(0, 1) ? "e" : "E"));
                    if ($urandom_range(0, 1))
                        push_sign();
                    push_digits($urandom_range(0, 3), 1'b0);
                end
            end
        end
        text_q.push_back({($urandom_range(0, 2) == 0), 8'($urandom)});
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++)
            text_q.push_back({($urandom_range(0, 3) == 0), 8'($urandom)});
        if ($urandom_range(0, 7) == 0)
            text_q[$urandom_range(0, text_q.size() - 1)] =
                {($urandom_range(0, 5) == 0), 8'($urandom)};
    endtask

    function automatic logic [15:0] pick_width(input int len);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'hFFFF;
        if (r == 6)
            return 16'($urandom);
        return 16'($urandom_range(0, len + 1));
    endfunction

    task automatic test_random_literals();
        int phase;
        int sent;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    set_decimal_point(".");
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    set_decimal_point(8'hFF);
                    idle_pct  = 54;
                    stall_pct = 0;
                end
                2:
                begin
                    set_decimal_point(",");
                    idle_pct  = 0;
                    stall_pct = 54;
                end
                default:
                begin
                    set_decimal_point(8'($urandom));
                    idle_pct  = 9;
                    stall_pct = 9;
                end
            endcase
            sent = 0;
            while (sent < 412)
            begin
                build_literal();
                send_text(pick_width(text_q.size()));
                sent += text_q.size();
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        dp_char    = flr_pkg::DECIMAL_POINT_RESET;
        lit_budget = 16'd0;
        clear_literal();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_start_and_width();
        test_literals();
        test_decimal_point();
        test_random_literals();
        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/flr_pkg.sv
rtl/flr_core.sv
rtl/float_literal_recognizer_top.sv
sim/float_literal_recognizer_top_test.sv
